/* hw/rtl/lhcad_pkg.sv */
// Package for the LoROM/HiROM cartridge address decoder.
// Holds the shared widths, map constants, codes and command types.
// No dependencies.
`default_nettype none

package lhcad_pkg;

  // Field and register widths
  localparam int unsigned BankW      = 8;
  localparam int unsigned AdrW       = 16;
  localparam int unsigned DataW      = 8;
  localparam int unsigned OffW       = 22;
  localparam int unsigned RomSizeW   = 23;
  localparam int unsigned SramCodeW  = 5;
  localparam int unsigned SramRawW   = 19;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 23;
  localparam int unsigned DivCntW    = 5;

  // Sizing defaults
  localparam int unsigned SramDepthDef = 131072;
  localparam int unsigned QueueDepth   = 2;

  // Memory map constants
  localparam logic [BankW-1:0] LoSramBankLo = 8'h70;
  localparam logic [BankW-1:0] WramBankLo   = 8'h7e;
  localparam logic [BankW-1:0] WramBankHi   = 8'h7f;
  localparam logic [BankW-1:0] LoSramBankHi = 8'hf0;
  localparam logic [AdrW-1:0]  HiSramAdr    = 16'h6000;
  localparam logic [AdrW-1:0]  RomAdr       = 16'h8000;
  localparam logic [6:0]       SysBankEnd   = 7'h40;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAP_MODE  = 2'd0,
    CFG_ROM_SIZE  = 2'd1,
    CFG_SRAM_CODE = 2'd2
  } cfg_reg_e;

  // Map modes
  typedef enum logic {
    MAP_LOROM = 1'b0,
    MAP_HIROM = 1'b1
  } map_mode_e;

  // Result targets
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_SRAM = 2'd2
  } target_e;

  // Decoded command kinds
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ROM     = 2'd1,
    CMD_SRAM_RD = 2'd2,
    CMD_SRAM_WR = 2'd3
  } cmd_kind_e;

  // Back end states
  typedef enum logic [2:0] {
    B_CLEAR = 3'd0,
    B_IDLE  = 3'd1,
    B_READ  = 3'd2,
    B_DIV   = 3'd3,
    B_DONE  = 3'd4
  } back_state_e;

  // Live configuration
  typedef struct packed {
    map_mode_e                map_mode;
    logic [RomSizeW-1:0]      rom_size;
    logic [SramCodeW-1:0]     sram_code;
  } cfg_t;

  // Command passed from front to back; addr is the ROM dividend or the SRAM index
  typedef struct packed {
    cmd_kind_e                kind;
    logic [OffW-1:0]          addr;
    logic [DataW-1:0]         wdata;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/lhcad_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module lhcad_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/lhcad_front.sv */
// Front end: accepts bus accesses and classifies them into commands.
// Depends on lhcad_pkg.
`default_nettype none

module lhcad_front
  import lhcad_pkg::*;
(
  input  wire logic               push,
  output logic                    full,
  input  wire logic               action_i,
  input  wire logic [BankW-1:0]   bank_i,
  input  wire logic [AdrW-1:0]    address_i,
  input  wire logic [DataW-1:0]   write_data_i,
  input  wire cfg_t               cfg_i,
  input  wire logic               q_full_i,
  input  wire logic               clearing_i,
  output logic                    q_push_o,
  output cmd_t                    q_cmd_o
);

  logic                  has_sram;
  logic                  sram_hit;
  logic                  rom_hit;
  logic [SramRawW-1:0]   raw;
  logic [SramRawW-1:0]   msk;
  logic [OffW-1:0]       off;
  logic [6:0]            canon;

  // Stall while the queue is full or the save RAM is being cleared
  assign full     = q_full_i | clearing_i;
  assign q_push_o = push & ~full;

  assign canon    = bank_i[6:0];
  assign has_sram = cfg_i.sram_code != '0;

  // Window decode for both maps
  always_comb begin
    if (cfg_i.map_mode == MAP_LOROM) begin
      sram_hit = ((bank_i >= LoSramBankLo && bank_i < WramBankLo) || bank_i >= LoSramBankHi)
                 && address_i < RomAdr && has_sram;
      raw      = {bank_i[3:0], address_i[14:0]};
      off      = {canon, address_i[14:0]};
    end else begin
      sram_hit = canon < SysBankEnd && address_i >= HiSramAdr && address_i < RomAdr
                 && has_sram;
      raw      = {bank_i[5:0], address_i[12:0]};
      off      = {bank_i[5:0], address_i};
    end
  end

  assign rom_hit = ~action_i && cfg_i.rom_size != '0 && bank_i != WramBankLo
                   && bank_i != WramBankHi && !(address_i < RomAdr && canon < SysBankEnd);

  // Save RAM size mask: bits below the size code
  always_comb begin
    for (int i = 0; i < SramRawW; i++) begin
      msk[i] = SramCodeW'(i) < cfg_i.sram_code;
    end
  end

  // Build the command
  always_comb begin
    q_cmd_o.wdata = write_data_i;
    if (sram_hit) begin
      q_cmd_o.kind = action_i ? CMD_SRAM_WR : CMD_SRAM_RD;
      q_cmd_o.addr = OffW'(raw & msk);
    end else if (rom_hit) begin
      q_cmd_o.kind = CMD_ROM;
      q_cmd_o.addr = off;
    end else begin
      q_cmd_o.kind = CMD_NONE;
      q_cmd_o.addr = '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lhcad_queue.sv */
// Short command queue between the front and back ends.
// Depends on lhcad_pkg.
`default_nettype none

module lhcad_queue
  import lhcad_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      data_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lhcad_back.sv */
// Back end: clears and accesses the save RAM, reduces ROM offsets, holds results.
// Depends on lhcad_pkg and lhcad_ram.
`default_nettype none

module lhcad_back
  import lhcad_pkg::*;
#(
  parameter int unsigned SRAM_DEPTH = SramDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [RomSizeW-1:0] rom_size_i,
  input  wire logic                q_empty_i,
  input  wire cmd_t                q_cmd_i,
  output logic                     q_pop_o,
  output logic                     clearing_o,
  output logic                     empty,
  input  wire logic                pop,
  output logic [1:0]               target_o,
  output logic [OffW-1:0]          rom_offset_o,
  output logic [DataW-1:0]         read_data_o
);

  localparam int unsigned AddrW = $clog2(SRAM_DEPTH);

  back_state_e         state_q, state_d;
  logic [AddrW-1:0]    clr_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [OffW-1:0]     rem_q;
  logic [OffW-1:0]     dvd_q;
  target_e             res_tgt_q;
  logic [OffW-1:0]     res_off_q;
  logic [DataW-1:0]    res_rd_q;
  logic                out_valid_q;
  target_e             out_tgt_q;
  logic [OffW-1:0]     out_off_q;
  logic [DataW-1:0]    out_rd_q;

  logic                ram_we;
  logic [AddrW-1:0]    ram_addr;
  logic [DataW-1:0]    ram_wdata;
  logic [DataW-1:0]    ram_rdata;
  logic                out_pop;
  logic                out_free;
  logic                out_load;
  logic [RomSizeW-1:0] shifted;
  logic [RomSizeW-1:0] diff;
  logic [OffW-1:0]     rem_nx;

  lhcad_ram #(
    .WIDTH (DataW),
    .DEPTH (SRAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_pop  = pop & out_valid_q;
  assign out_free = ~out_valid_q | out_pop;

  // Restoring remainder step, one dividend bit per cycle
  assign shifted = {rem_q, dvd_q[OffW-1]};
  assign diff    = shifted - rom_size_i;
  assign rem_nx  = (shifted >= rom_size_i) ? diff[OffW-1:0] : shifted[OffW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_q == AddrW'(SRAM_DEPTH - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          case (q_cmd_i.kind)
            CMD_ROM:     state_d = B_DIV;
            CMD_SRAM_RD: state_d = B_READ;
            default:     state_d = B_DONE;
          endcase
        end
      end
      B_READ: state_d = B_DONE;
      B_DIV: begin
        if (cnt_q == '0) state_d = B_DONE;
      end
      B_DONE: begin
        if (out_free) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    clearing_o = state_q == B_CLEAR;
    q_pop_o    = state_q == B_IDLE && !q_empty_i;
    out_load   = state_q == B_DONE && out_free;
    ram_we     = clearing_o || (q_pop_o && q_cmd_i.kind == CMD_SRAM_WR);
    ram_addr   = clearing_o ? clr_q : q_cmd_i.addr[AddrW-1:0];
    ram_wdata  = clearing_o ? '0 : q_cmd_i.wdata;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clearing_o) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (q_pop_o) begin
        cnt_q <= DivCntW'(OffW - 1);
      end else if (state_q == B_DIV) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result datapath
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_off_q <= '0;
      res_rd_q  <= '0;
      rem_q     <= '0;
      dvd_q     <= q_cmd_i.addr;
      case (q_cmd_i.kind)
        CMD_ROM:     res_tgt_q <= TGT_ROM;
        CMD_SRAM_RD: res_tgt_q <= TGT_SRAM;
        CMD_SRAM_WR: res_tgt_q <= TGT_SRAM;
        default:     res_tgt_q <= TGT_NONE;
      endcase
    end
    if (state_q == B_DIV) begin
      rem_q <= rem_nx;
      dvd_q <= {dvd_q[OffW-2:0], 1'b0};
      if (cnt_q == '0) res_off_q <= rem_nx;
    end
    if (state_q == B_READ) begin
      res_rd_q <= ram_rdata;
    end
    if (out_load) begin
      out_tgt_q <= res_tgt_q;
      out_off_q <= res_off_q;
      out_rd_q  <= res_rd_q;
    end
  end

  assign empty        = ~out_valid_q;
  assign target_o     = out_tgt_q;
  assign rom_offset_o = out_off_q;
  assign read_data_o  = out_rd_q;

endmodule

`default_nettype wire

/* hw/rtl/lorom_hirom_cart_address_decoder_top.sv */
// Top level of the LoROM/HiROM cartridge address decoder.
// Depends on lhcad_pkg, lhcad_front, lhcad_queue, lhcad_back and lhcad_ram.
`default_nettype none

// Decodes one CPU bus access per item into a target (none, ROM or save RAM), a
// ROM offset reduced modulo rom_size, and a save RAM read byte. After reset the
// save RAM (SRAM_DEPTH bytes, 131072 by default) is cleared one byte per cycle
// while full stays high; configuration writes are taken throughout. A ROM access
// runs the modulo in the back end one offset bit per cycle. A save RAM read
// passes through the registered RAM read; a write or an unmapped access goes
// straight to the result. A two-entry command queue in front and a
// one-entry result register behind let inputs and results stall independently.
module lorom_hirom_cart_address_decoder_top
  import lhcad_pkg::*;
#(
  parameter int unsigned SRAM_DEPTH = SramDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                action_i,
  input  wire logic [BankW-1:0]    bank_i,
  input  wire logic [AdrW-1:0]     address_i,
  input  wire logic [DataW-1:0]    write_data_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [1:0]               target_o,
  output logic [OffW-1:0]          rom_offset_o,
  output logic [DataW-1:0]         read_data_o
);

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_empty, clearing;
  cmd_t q_cmd_in, q_cmd_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_mode  <= MAP_LOROM;
      cfg_q.rom_size  <= '0;
      cfg_q.sram_code <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_MODE:  cfg_q.map_mode  <= map_mode_e'(cfg_wdata_i[0]);
        CFG_ROM_SIZE:  cfg_q.rom_size  <= cfg_wdata_i[RomSizeW-1:0];
        CFG_SRAM_CODE: cfg_q.sram_code <= cfg_wdata_i[SramCodeW-1:0];
        default: ;
      endcase
    end
  end

  lhcad_front u_front (
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .bank_i       (bank_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cfg_i        (cfg_q),
    .q_full_i     (q_full),
    .clearing_i   (clearing),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in)
  );

  lhcad_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_cmd_out)
  );

  lhcad_back #(
    .SRAM_DEPTH (SRAM_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rom_size_i   (cfg_q.rom_size),
    .q_empty_i    (q_empty),
    .q_cmd_i      (q_cmd_out),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .empty        (empty),
    .pop          (pop),
    .target_o     (target_o),
    .rom_offset_o (rom_offset_o),
    .read_data_o  (read_data_o)
  );

endmodule

`default_nettype wire
